FILE: rtl/pags_pkg.sv
// -----------------------------------------------------------------------------
// pags_pkg
// shared widths, codes and types of the pointer acceleration gain scaler
// -----------------------------------------------------------------------------
package pags_pkg;

   localparam int DataW      = 16;
   localparam int GainW      = 13;
   localparam int CarryW     = 9;
   localparam int SumW       = 20;
   localparam int MilliW     = 14;
   localparam int AxisW      = 2;
   localparam int UserW      = 3;
   localparam int AccW       = 30;
   localparam int DivNumW    = 28;
   localparam int DivDenW    = 16;
   localparam int CsrAddrW   = 3;
   localparam int FracW      = 8;
   localparam int MulBW      = 22;
   localparam int RecipShift = 22;

   localparam logic [GainW-1:0]   UnityQ8   = GainW'(256);
   localparam logic [MilliW-1:0]  MilliCfg  = MilliW'(1000);
   localparam logic [GainW-1:0]   GainMax   = GainW'(((2**MilliW - 1) * 256) / 1000);

   // x * 256 / 1000 as (x * RecipMilliQ8) >> RecipShift, exact for 14-bit x
   localparam logic [MulBW-1:0]   RecipMilliQ8 = MulBW'(1073742);

   localparam logic [AxisW-1:0] AxisX = 2'd0;
   localparam logic [AxisW-1:0] AxisY = 2'd1;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_ACCEL_ENABLE    = 3'd0,
      CSR_MAX_GAIN_MILLI  = 3'd1,
      CSR_SPEED_THRESHOLD = 3'd2,
      CSR_RAMP_SPAN       = 3'd3,
      CSR_LOW_GAIN_MILLI  = 3'd4,
      CSR_SLOW_ZONE_END   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                start;
      logic [DivNumW-1:0]  num;
      logic [DivDenW-1:0]  den;
   } div_req_type;

endpackage

FILE: rtl/pags_div.sv
// -----------------------------------------------------------------------------
// pags_div
// serial restoring divider, one quotient bit per cycle
// -----------------------------------------------------------------------------
module pags_div (
   input  logic                          clock,
   input  logic                          reset,
   input  pags_pkg::div_req_type         div_req,
   output logic                          div_done,
   output logic [pags_pkg::DivNumW-1:0]  div_quot
);

   localparam int NumW = pags_pkg::DivNumW;
   localparam int DenW = pags_pkg::DivDenW;
   localparam int CntW = $clog2(NumW);

   logic            busy_ff;
   logic            done_ff;
   logic [CntW-1:0] cnt_ff;
   logic [NumW-1:0] num_ff;
   logic [DenW-1:0] rem_ff;
   logic [DenW-1:0] den_ff;

   logic [DenW:0]   trial;
   logic            qbit_in;
   logic [DenW-1:0] rem_in;

   always_comb begin
      trial   = {rem_ff, num_ff[NumW-1]};
      qbit_in = (trial >= {1'b0, den_ff});
      rem_in  = qbit_in ? DenW'(trial - {1'b0, den_ff}) : trial[DenW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= div_req.num;
            den_ff  <= div_req.den;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            num_ff <= {num_ff[NumW-2:0], qbit_in};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CntW'(NumW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_done = done_ff;
   assign div_quot = num_ff;

endmodule

FILE: rtl/pags_mul.sv
// -----------------------------------------------------------------------------
// pags_mul
// shared unsigned multiplier with registered product
// -----------------------------------------------------------------------------
module pags_mul (
   input  logic                                        clock,
   input  logic [pags_pkg::DataW-1:0]                  mul_a,
   input  logic [pags_pkg::MulBW-1:0]                  mul_b,
   output logic [pags_pkg::DataW+pags_pkg::MulBW-1:0]  mul_prod
);

   logic [pags_pkg::DataW+pags_pkg::MulBW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign mul_prod = prod_ff;

endmodule

FILE: rtl/pointer_accel_gain_scaler_core.sv
// -----------------------------------------------------------------------------
// pointer_accel_gain_scaler_core
// scales x/y motion by a q8 gain and updates the gain per poll frame
//
//   channel  dir  fields
//   req_     in   tdata: delta | tuser: axis, bypass | tlast: frame_end
//   rsp_     out  tdata: scaled_delta
//   csr_     in   csr_addr register index, csr_wdata value
//
// one beat at a time: pass-through and bypass beats go to the finish step; a
// motion beat runs multiply, carry add and round; a frame end beat adds curve
// select, a reciprocal multiply for the q8 gain, a 28-step serial ramp divide
// a finished result waits in the output register while the next beat is taken
// synchronous active-high reset restores unity gain, zero sum and carries
// -----------------------------------------------------------------------------
module pointer_accel_gain_scaler_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pags_pkg::DataW-1:0]        req_tdata,   // delta
   input  logic [pags_pkg::UserW-1:0]        req_tuser,   // axis[1:0], bypass[2]
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pags_pkg::DataW-1:0]        rsp_tdata,   // scaled_delta
   input  logic                              csr_we,
   input  logic [pags_pkg::CsrAddrW-1:0]     csr_addr,
   input  logic [pags_pkg::DataW-1:0]        csr_wdata
);

   localparam int DataW   = pags_pkg::DataW;
   localparam int GainW   = pags_pkg::GainW;
   localparam int CarryW  = pags_pkg::CarryW;
   localparam int SumW    = pags_pkg::SumW;
   localparam int MilliW  = pags_pkg::MilliW;
   localparam int AccW    = pags_pkg::AccW;
   localparam int FracW   = pags_pkg::FracW;
   localparam int NumW    = pags_pkg::DivNumW;
   localparam int MulBW   = pags_pkg::MulBW;
   localparam int ProdW   = DataW + MulBW;
   localparam int RecipSh = pags_pkg::RecipShift;
   localparam int QW      = AccW - FracW;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_ADDC,
      S_ROUND,
      S_CURVE,
      S_RECIP,
      S_LOW_Q8,
      S_MAX_Q8,
      S_RAMP_MUL,
      S_RAMP_GO,
      S_RAMP_DIV,
      S_FIN
   } state_type;

   // configuration
   logic              accel_enable_ff;
   logic [MilliW-1:0] max_gain_ff;
   logic [DataW-1:0]  thr_ff;
   logic [DataW-1:0]  span_ff;
   logic [MilliW-1:0] low_gain_ff;
   logic [DataW-1:0]  send_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_enable_ff <= 1'b0;
         max_gain_ff     <= MilliW'(2000);
         thr_ff          <= '0;
         span_ff         <= DataW'(1);
         low_gain_ff     <= pags_pkg::MilliCfg;
         send_cfg_ff     <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            pags_pkg::CSR_ACCEL_ENABLE:    accel_enable_ff <= csr_wdata[0];
            pags_pkg::CSR_MAX_GAIN_MILLI:  max_gain_ff     <= csr_wdata[MilliW-1:0];
            pags_pkg::CSR_SPEED_THRESHOLD: thr_ff          <= csr_wdata;
            pags_pkg::CSR_RAMP_SPAN:       span_ff         <= csr_wdata;
            pags_pkg::CSR_LOW_GAIN_MILLI:  low_gain_ff     <= csr_wdata[MilliW-1:0];
            pags_pkg::CSR_SLOW_ZONE_END:   send_cfg_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // datapath state
   state_type                     state_ff;
   logic                          rsp_valid_ff;
   logic [DataW-1:0]              rsp_data_ff;
   logic [DataW-1:0]              res_ff;
   logic                          axis_y_ff;
   logic                          frame_end_ff;
   logic                          neg_ff;
   logic signed [CarryW-1:0]      carry_x_ff;
   logic signed [CarryW-1:0]      carry_y_ff;
   logic [SumW-1:0]               sum_ff;
   logic [SumW-1:0]               mag_ff;
   logic [GainW-1:0]              gain_ff;
   logic [GainW-1:0]              low_ff;
   logic [DataW-1:0]              send_ff;
   logic [DataW-1:0]              den_ff;
   logic [DataW-1:0]              mul_a_ff;
   logic [MulBW-1:0]              mul_b_ff;
   logic signed [AccW-1:0]        v_ff;

   logic [ProdW-1:0]              prod;
   pags_pkg::div_req_type         div_req;
   logic                          div_done;
   logic [NumW-1:0]               div_quot;

   pags_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a_ff),
      .mul_b    (mul_b_ff),
      .mul_prod (prod)
   );

   pags_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   // input decode
   logic                 accept;
   logic                 is_motion;
   logic [GainW-1:0]     gain_eff;
   logic [DataW-1:0]     delta_mag;

   // scaling
   logic signed [AccW-1:0]   prod_s;
   logic signed [CarryW-1:0] carry_sel;
   logic signed [AccW-1:0]   v_in;
   logic [AccW-1:0]          abs_v;
   logic [QW-1:0]            qm;
   logic [FracW-1:0]         rm;
   logic [DataW-1:0]         res_in;
   logic signed [CarryW-1:0] carry_in;
   logic [SumW:0]            sum_wide;
   logic [SumW-1:0]          sum_in;

   // curve
   logic                 m_le_thr;
   logic [DataW-1:0]     send_cap;
   logic                 slow_off;
   logic [MilliW-1:0]    max_eff;
   logic [DataW-1:0]     span_eff;
   logic [GainW-1:0]     recip_q8;
   logic [GainW-1:0]     quot_g;
   logic [SumW-1:0]      over_w;
   logic [DataW-1:0]     over;
   logic [GainW-1:0]     gain_in;

   always_comb begin
      accept    = req_tvalid && req_tready;
      is_motion = (req_tuser[1:0] == pags_pkg::AxisX) || (req_tuser[1:0] == pags_pkg::AxisY);
      gain_eff  = (gain_ff == '0) ? pags_pkg::UnityQ8 : gain_ff;
      delta_mag = req_tdata[DataW-1] ? DataW'(-req_tdata) : req_tdata;

      prod_s    = $signed({2'b00, prod[AccW-3:0]});
      carry_sel = axis_y_ff ? carry_y_ff : carry_x_ff;
      v_in      = (neg_ff ? -prod_s : prod_s)
                  + {{(AccW-CarryW){carry_sel[CarryW-1]}}, carry_sel};

      abs_v = v_ff[AccW-1] ? AccW'(-v_ff) : AccW'(v_ff);
      qm    = abs_v[AccW-1:FracW];
      rm    = abs_v[FracW-1:0];
      if (v_ff[AccW-1]) begin
         res_in   = (qm > QW'(32768)) ? 16'h8000 : DataW'(~qm[DataW-1:0] + 1'b1);
         carry_in = CarryW'(-$signed({1'b0, rm}));
      end else begin
         res_in   = (qm > QW'(32767)) ? 16'h7fff : qm[DataW-1:0];
         carry_in = $signed({1'b0, rm});
      end
      sum_wide = {1'b0, sum_ff} + (SumW+1)'(mul_a_ff);
      sum_in   = sum_wide[SumW] ? {SumW{1'b1}} : sum_wide[SumW-1:0];

      m_le_thr = (mag_ff <= SumW'(thr_ff));
      send_cap = (send_cfg_ff > thr_ff) ? thr_ff : send_cfg_ff;
      slow_off = (low_gain_ff == pags_pkg::MilliCfg) || (low_gain_ff == '0) ||
                 (send_cap == '0);
      max_eff  = (max_gain_ff < pags_pkg::MilliCfg) ? pags_pkg::MilliCfg : max_gain_ff;
      span_eff = (span_ff == '0) ? DataW'(1) : span_ff;
      recip_q8 = prod[RecipSh +: GainW];
      quot_g   = div_quot[GainW-1:0];
      over_w   = mag_ff - SumW'(thr_ff);
      over     = (over_w > SumW'(span_eff)) ? span_eff : over_w[DataW-1:0];
      gain_in  = neg_ff ? GainW'(low_ff - quot_g) : GainW'(low_ff + quot_g);

      div_req       = '0;
      div_req.start = (state_ff == S_RAMP_GO);
      div_req.num   = prod[NumW-1:0];
      div_req.den   = den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         carry_x_ff   <= '0;
         carry_y_ff   <= '0;
         sum_ff       <= '0;
         gain_ff      <= pags_pkg::UnityQ8;
      end else begin
         if (rsp_tready && (state_ff != S_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  axis_y_ff    <= req_tuser[0];
                  frame_end_ff <= req_tlast;
                  res_ff       <= req_tdata;
                  if (is_motion && req_tuser[2]) begin
                     carry_x_ff <= '0;
                     carry_y_ff <= '0;
                     sum_ff     <= '0;
                     gain_ff    <= pags_pkg::UnityQ8;
                     state_ff   <= S_FIN;
                  end else if (is_motion) begin
                     gain_ff  <= gain_eff;
                     mul_a_ff <= delta_mag;
                     mul_b_ff <= MulBW'(gain_eff);
                     neg_ff   <= req_tdata[DataW-1];
                     state_ff <= S_MUL;
                  end else begin
                     state_ff <= S_FIN;
                  end
               end
            end
            S_MUL: begin
               state_ff <= S_ADDC;
            end
            S_ADDC: begin
               v_ff     <= v_in;
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               res_ff <= res_in;
               if (axis_y_ff) begin
                  carry_y_ff <= carry_in;
               end else begin
                  carry_x_ff <= carry_in;
               end
               if (frame_end_ff) begin
                  mag_ff   <= sum_in;
                  sum_ff   <= '0;
                  state_ff <= S_CURVE;
               end else begin
                  sum_ff   <= sum_in;
                  state_ff <= S_FIN;
               end
            end
            S_CURVE: begin
               send_ff <= send_cap;
               if (!accel_enable_ff || (m_le_thr && slow_off)) begin
                  gain_ff  <= pags_pkg::UnityQ8;
                  state_ff <= S_FIN;
               end else begin
                  mul_a_ff <= m_le_thr ? DataW'(low_gain_ff) : DataW'(max_eff);
                  mul_b_ff <= pags_pkg::RecipMilliQ8;
                  state_ff <= S_RECIP;
               end
            end
            S_RECIP: begin
               state_ff <= m_le_thr ? S_LOW_Q8 : S_MAX_Q8;
            end
            S_LOW_Q8: begin
               low_ff <= recip_q8;
               if (mag_ff <= SumW'(send_ff)) begin
                  gain_ff  <= recip_q8;
                  state_ff <= S_FIN;
               end else if (mag_ff == SumW'(thr_ff)) begin
                  gain_ff  <= pags_pkg::UnityQ8;
                  state_ff <= S_FIN;
               end else begin
                  neg_ff   <= (recip_q8 > pags_pkg::UnityQ8);
                  mul_a_ff <= (recip_q8 > pags_pkg::UnityQ8)
                              ? DataW'(recip_q8 - pags_pkg::UnityQ8)
                              : DataW'(pags_pkg::UnityQ8 - recip_q8);
                  mul_b_ff <= MulBW'(mag_ff - SumW'(send_ff));
                  den_ff   <= thr_ff - send_ff;
                  state_ff <= S_RAMP_MUL;
               end
            end
            S_MAX_Q8: begin
               low_ff   <= pags_pkg::UnityQ8;
               neg_ff   <= 1'b0;
               mul_a_ff <= DataW'(recip_q8 - pags_pkg::UnityQ8);
               mul_b_ff <= MulBW'(over);
               den_ff   <= span_eff;
               state_ff <= S_RAMP_MUL;
            end
            S_RAMP_MUL: begin
               state_ff <= S_RAMP_GO;
            end
            S_RAMP_GO: begin
               state_ff <= S_RAMP_DIV;
            end
            S_RAMP_DIV: begin
               if (div_done) begin
                  gain_ff  <= gain_in;
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while a beat is in progress");

   a_carry_x_range: assert property (@(posedge clock) disable iff (reset)
      carry_x_ff != $signed({1'b1, {(CarryW-1){1'b0}}}))
      else $error("x carry out of range");

   a_carry_y_range: assert property (@(posedge clock) disable iff (reset)
      carry_y_ff != $signed({1'b1, {(CarryW-1){1'b0}}}))
      else $error("y carry out of range");

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= pags_pkg::GainMax)
      else $error("gain above curve maximum");

   a_result_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_FIN))
      else $error("result presented outside the finish step");

endmodule

FILE: test/pointer_accel_gain_scaler_core_tb.sv
// -----------------------------------------------------------------------------
// pointer_accel_gain_scaler_core_tb
// drives x/y motion, other events and bypass beats through the gain scaler,
// predicts each scaled delta from its own copy of the gain, carry and frame
// sum state, and compares every result beat in order; register settings are
// changed only while the block is idle, under four idling mixes
// -----------------------------------------------------------------------------
module pointer_accel_gain_scaler_core_tb;

   localparam int DataW    = pags_pkg::DataW;
   localparam int GainW    = pags_pkg::GainW;
   localparam int SumW     = pags_pkg::SumW;
   localparam int MilliW   = pags_pkg::MilliW;
   localparam int AxisW    = pags_pkg::AxisW;
   localparam int UserW    = pags_pkg::UserW;
   localparam int CsrAddrW = pags_pkg::CsrAddrW;

   localparam logic [AxisW-1:0]    AxisOther     = 2'd2;
   localparam logic [AxisW-1:0]    AxisUndef     = 2'd3;
   localparam logic [CsrAddrW-1:0] CsrUnmappedLo = 3'd6;
   localparam logic [CsrAddrW-1:0] CsrUnmappedHi = 3'd7;
   localparam longint SumLimit     = (longint'(1) << SumW) - 1;
   localparam int     SettleCycles = 100;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [DataW-1:0]    req_tdata   = '0;
   logic [UserW-1:0]    req_tuser   = '0;
   logic                req_tlast   = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [DataW-1:0]    rsp_tdata;
   logic                csr_we      = 1'b0;
   logic [CsrAddrW-1:0] csr_addr    = '0;
   logic [DataW-1:0]    csr_wdata   = '0;

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;

   // register copies
   logic              cfg_accel_en  = 1'b0;
   logic [MilliW-1:0] cfg_max_gain  = 14'd2000;
   logic [15:0]       cfg_threshold = 16'd0;
   logic [15:0]       cfg_ramp_span = 16'd1;
   logic [MilliW-1:0] cfg_low_gain  = 14'd1000;
   logic [15:0]       cfg_slow_end  = 16'd0;

   // predicted block state
   longint            carry_x   = 0;
   longint            carry_y   = 0;
   longint            frame_sum = 0;
   logic [GainW-1:0]  gain_q8   = pags_pkg::UnityQ8;

   logic [DataW-1:0]  scaled_q[$];
   logic [DataW-1:0]  scaled_want;

   pointer_accel_gain_scaler_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (scaled_q.size() == 0) begin
            $error("scaled_delta beat with nothing expected: actual %0d", $signed(rsp_tdata));
            fail_count++;
         end else begin
            scaled_want = scaled_q.pop_front();
            if (rsp_tdata !== scaled_want) begin
               $error("scaled_delta expected %0d actual %0d",
                      $signed(scaled_want), $signed(rsp_tdata));
               fail_count++;
            end
         end
      end
   end

   function automatic logic [GainW-1:0] frame_gain(input longint mag);
      longint unity, milli, thr, span, maxm, lowm, zend, low_q8, lo, hi, over, max_q8, g;
      unity = longint'(pags_pkg::UnityQ8);
      milli = longint'(pags_pkg::MilliCfg);
      thr   = longint'(cfg_threshold);
      span  = (cfg_ramp_span == 0) ? 1 : longint'(cfg_ramp_span);
      maxm  = (longint'(cfg_max_gain) < milli) ? milli : longint'(cfg_max_gain);
      if (!cfg_accel_en) return pags_pkg::UnityQ8;
      if (mag <= thr) begin
         lowm = longint'(cfg_low_gain);
         zend = longint'(cfg_slow_end);
         if (zend > thr) zend = thr;
         if (lowm == milli || lowm == 0 || zend == 0) return pags_pkg::UnityQ8;
         low_q8 = (lowm * unity) / milli;
         if (mag <= zend) g = low_q8;
         else if (mag >= thr) g = unity;
         else g = low_q8 + ((unity - low_q8) * (mag - zend)) / (thr - zend);
         lo = (low_q8 < unity) ? low_q8 : unity;
         hi = (low_q8 > unity) ? low_q8 : unity;
         if (g < lo) g = lo;
         if (g > hi) g = hi;
         return g[GainW-1:0];
      end
      over   = mag - thr;
      max_q8 = (maxm * unity) / milli;
      if (over > span) over = span;
      g = unity + ((max_q8 - unity) * over) / span;
      if (g < unity) g = unity;
      return g[GainW-1:0];
   endfunction

   task automatic scale_motion(input logic [AxisW-1:0] axis, input logic [DataW-1:0] delta,
                               input logic last, input logic byp,
                               output logic [DataW-1:0] scaled);
      longint d, v, q, mag;
      d = longint'($signed(delta));
      scaled = delta;
      if (axis == pags_pkg::AxisX || axis == pags_pkg::AxisY) begin
         if (byp) begin
            carry_x   = 0;
            carry_y   = 0;
            frame_sum = 0;
            gain_q8   = pags_pkg::UnityQ8;
         end else begin
            mag = (d < 0) ? -d : d;
            if (gain_q8 == 0) gain_q8 = pags_pkg::UnityQ8;
            v = d * longint'(gain_q8) + ((axis == pags_pkg::AxisX) ? carry_x : carry_y);
            q = v / longint'(pags_pkg::UnityQ8);
            if (axis == pags_pkg::AxisX) carry_x = v - q * longint'(pags_pkg::UnityQ8);
            else carry_y = v - q * longint'(pags_pkg::UnityQ8);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            scaled = q[DataW-1:0];
            frame_sum = (frame_sum + mag > SumLimit) ? SumLimit : frame_sum + mag;
            if (last) begin
               gain_q8   = frame_gain(frame_sum);
               frame_sum = 0;
            end
         end
      end
   endtask

   task automatic send_beat(input logic [AxisW-1:0] axis, input logic [DataW-1:0] delta,
                            input logic last, input logic byp);
      logic [DataW-1:0] scaled;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= delta;
      req_tuser  <= {byp, axis};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scale_motion(axis, delta, last, byp, scaled);
      scaled_q.push_back(scaled);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (scaled_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrAddrW-1:0] addr, input logic [DataW-1:0] value);
      wait_drained();
      // quiet gap before each register write
      repeat (SettleCycles) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         pags_pkg::CSR_ACCEL_ENABLE:    cfg_accel_en  = value[0];
         pags_pkg::CSR_MAX_GAIN_MILLI:  cfg_max_gain  = value[MilliW-1:0];
         pags_pkg::CSR_SPEED_THRESHOLD: cfg_threshold = value;
         pags_pkg::CSR_RAMP_SPAN:       cfg_ramp_span = value;
         pags_pkg::CSR_LOW_GAIN_MILLI:  cfg_low_gain  = value[MilliW-1:0];
         pags_pkg::CSR_SLOW_ZONE_END:   cfg_slow_end  = value;
         default: ;
      endcase
   endtask

   function automatic logic [DataW-1:0] random_delta(input logic heavy);
      int pick;
      pick = $urandom_range(99);
      if (heavy) return $urandom_range(1) ? DataW'(32767 - $urandom_range(2000))
                                          : DataW'(-32768 + $urandom_range(2000));
      if (pick < 60) return DataW'($signed(32'($urandom_range(128))) - 64);
      if (pick < 85) return DataW'($signed(32'($urandom_range(4000))) - 2000);
      return DataW'($urandom);
   endfunction

   task automatic pick_config();
      logic [DataW-1:0] thr;
      write_csr(pags_pkg::CSR_ACCEL_ENABLE, DataW'($urandom_range(7) != 0));
      case ($urandom_range(4))
         0: write_csr(pags_pkg::CSR_MAX_GAIN_MILLI, 16'd0);
         1: write_csr(pags_pkg::CSR_MAX_GAIN_MILLI, 16'd999);
         2: write_csr(pags_pkg::CSR_MAX_GAIN_MILLI, 16'd16000);
         3: write_csr(pags_pkg::CSR_MAX_GAIN_MILLI, DataW'($urandom_range(16000)));
         default: write_csr(pags_pkg::CSR_MAX_GAIN_MILLI,
                            DataW'($urandom_range(4000, 1000)));
      endcase
      case ($urandom_range(4))
         0: thr = 16'd0;
         1: thr = 16'd65535;
         default: thr = DataW'($urandom_range(1500));
      endcase
      write_csr(pags_pkg::CSR_SPEED_THRESHOLD, thr);
      case ($urandom_range(4))
         0: write_csr(pags_pkg::CSR_RAMP_SPAN, 16'd0);
         1: write_csr(pags_pkg::CSR_RAMP_SPAN, 16'd1);
         2: write_csr(pags_pkg::CSR_RAMP_SPAN, 16'd65535);
         default: write_csr(pags_pkg::CSR_RAMP_SPAN, DataW'($urandom_range(2000, 1)));
      endcase
      case ($urandom_range(5))
         0: write_csr(pags_pkg::CSR_LOW_GAIN_MILLI, 16'd0);
         1: write_csr(pags_pkg::CSR_LOW_GAIN_MILLI, 16'd1000);
         2: write_csr(pags_pkg::CSR_LOW_GAIN_MILLI, 16'd16000);
         3: write_csr(pags_pkg::CSR_LOW_GAIN_MILLI, DataW'($urandom_range(999)));
         default: write_csr(pags_pkg::CSR_LOW_GAIN_MILLI, DataW'($urandom_range(16000)));
      endcase
      case ($urandom_range(3))
         0: write_csr(pags_pkg::CSR_SLOW_ZONE_END, 16'd0);
         1: write_csr(pags_pkg::CSR_SLOW_ZONE_END, 16'd65535);
         default: write_csr(pags_pkg::CSR_SLOW_ZONE_END, DataW'($urandom_range(thr)));
      endcase
      if ($urandom_range(3) == 0)
         write_csr($urandom_range(1) ? CsrUnmappedHi : CsrUnmappedLo, DataW'($urandom));
   endtask

   task automatic run_frames(input int motion_beats);
      int done, len, k;
      logic last, heavy;
      done = 0;
      while (done < motion_beats) begin
         heavy = ($urandom_range(19) == 0);
         len   = heavy ? $urandom_range(40, 36) : $urandom_range(8, 1);
         for (k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0)
               send_beat($urandom_range(1) ? AxisUndef : AxisOther, DataW'($urandom),
                         1'($urandom), 1'($urandom));
            last = (k == len - 1);
            // broken frames: a missing or an early frame end
            if ($urandom_range(29) == 0) last = ~last;
            send_beat($urandom_range(1) ? pags_pkg::AxisY : pags_pkg::AxisX,
                      random_delta(heavy), last, $urandom_range(49) == 0);
            done++;
         end
         if ($urandom_range(59) == 0) wait_drained();
      end
   endtask

   task automatic test_passthrough();
      send_beat(pags_pkg::AxisX, 16'd1, 1'b0, 1'b0);
      send_beat(pags_pkg::AxisX, 16'hFFFF, 1'b0, 1'b0);
      send_beat(pags_pkg::AxisX, 16'h7FFF, 1'b0, 1'b0);
      send_beat(pags_pkg::AxisX, 16'h8000, 1'b0, 1'b0);
      send_beat(pags_pkg::AxisY, 16'd0, 1'b1, 1'b0);
      send_beat(AxisOther, 16'h8001, 1'b1, 1'b1);
      send_beat(AxisUndef, 16'h7FFE, 1'b1, 1'b1);
      send_beat(pags_pkg::AxisX, 16'h1234, 1'b1, 1'b1);
      send_beat(pags_pkg::AxisY, 16'hFEDC, 1'b0, 1'b1);
   endtask

   task automatic test_output_saturation();
      write_csr(pags_pkg::CSR_ACCEL_ENABLE, 16'd1);
      write_csr(pags_pkg::CSR_MAX_GAIN_MILLI, 16'd16000);
      write_csr(pags_pkg::CSR_SPEED_THRESHOLD, 16'd0);
      write_csr(pags_pkg::CSR_RAMP_SPAN, 16'd1);
      // maximum gain for the following frame
      send_beat(pags_pkg::AxisX, 16'd5, 1'b1, 1'b0);
      send_beat(pags_pkg::AxisX, 16'h7FFF, 1'b0, 1'b0);
      send_beat(pags_pkg::AxisX, 16'h8000, 1'b0, 1'b0);
      send_beat(pags_pkg::AxisY, 16'd9, 1'b0, 1'b0);
      send_beat(pags_pkg::AxisY, 16'hFFFD, 1'b0, 1'b0);
      send_beat(pags_pkg::AxisY, 16'h8000, 1'b1, 1'b0);
      send_beat(pags_pkg::AxisX, 16'd3, 1'b0, 1'b0);
   endtask

   task automatic test_zero_gain();
      write_csr(pags_pkg::CSR_SPEED_THRESHOLD, 16'd100);
      write_csr(pags_pkg::CSR_SLOW_ZONE_END, 16'd50);
      write_csr(pags_pkg::CSR_LOW_GAIN_MILLI, 16'd1);
      send_beat(pags_pkg::AxisX, 16'd10, 1'b1, 1'b0);
      send_beat(pags_pkg::AxisX, 16'd7, 1'b0, 1'b0);
      send_beat(pags_pkg::AxisY, 16'hFFFD, 1'b1, 1'b0);
      // half gain in the slow zone exercises the carry
      write_csr(pags_pkg::CSR_LOW_GAIN_MILLI, 16'd500);
      send_beat(pags_pkg::AxisX, 16'd30, 1'b1, 1'b0);
      send_beat(pags_pkg::AxisX, 16'd3, 1'b0, 1'b0);
      send_beat(pags_pkg::AxisX, 16'd1, 1'b0, 1'b0);
      send_beat(pags_pkg::AxisY, 16'hFFFB, 1'b0, 1'b0);
      send_beat(pags_pkg::AxisY, 16'd40, 1'b1, 1'b0);
      send_beat(pags_pkg::AxisX, 16'd77, 1'b0, 1'b0);
   endtask

   task automatic test_register_masking();
      write_csr(pags_pkg::CSR_ACCEL_ENABLE, 16'hFFFE);
      write_csr(pags_pkg::CSR_MAX_GAIN_MILLI, 16'hFFFF);
      write_csr(pags_pkg::CSR_LOW_GAIN_MILLI, 16'hFFFF);
      write_csr(CsrUnmappedLo, 16'hFFFF);
      write_csr(CsrUnmappedHi, 16'hFFFF);
      send_beat(pags_pkg::AxisX, 16'd200, 1'b1, 1'b0);
      send_beat(pags_pkg::AxisX, 16'd200, 1'b0, 1'b0);
      write_csr(pags_pkg::CSR_ACCEL_ENABLE, 16'hFFFF);
      write_csr(pags_pkg::CSR_SPEED_THRESHOLD, 16'd0);
      write_csr(pags_pkg::CSR_RAMP_SPAN, 16'd0);
      send_beat(pags_pkg::AxisY, 16'd200, 1'b1, 1'b0);
      send_beat(pags_pkg::AxisY, 16'hFF38, 1'b0, 1'b0);
   endtask

   task automatic test_random_traffic();
      int phase, seg;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 52; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 52; end
            default: begin send_gap_pct = 28; recv_stall_pct = 28; end
         endcase
         for (seg = 0; seg < 4; seg++) begin
            pick_config();
            run_frames(95);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_passthrough();
      test_output_saturation();
      test_zero_gain();
      test_register_masking();
      test_random_traffic();
      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("[pointer_accel_gain_scaler_core] OK");
      end else begin
         $display("[pointer_accel_gain_scaler_core] ERROR");
      end
      $finish;
   end

   initial begin
      #(8 * 1000000);
      $display("[pointer_accel_gain_scaler_core] ERROR");
      $finish;
   end

endmodule
